// ----- rtl/core/trial_division_prime_test_defines.svh -----
// Assertion macros used by the checker module tdpt_chk.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// Property checked on every edge outside reset.
`define TDPT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must sit low at every edge while reset is held.
`define TDPT_ASSERT_LOW_IN_RST(lbl, clk, rst_n, sig, msg) \
	lbl: assert property (@(posedge clk) !rst_n |-> !sig) else $error(msg);

`endif

// ----- rtl/core/tdpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

	localparam int NUMBER_WIDTH = 31;
	localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);

	localparam logic [NUMBER_WIDTH:0] SMALL_LIMIT = (NUMBER_WIDTH + 1)'(4);
	localparam logic [NUMBER_WIDTH:0] TWO_WIDE = (NUMBER_WIDTH + 1)'(2);
	localparam logic [NUMBER_WIDTH-1:0] FIRST_DIVISOR = NUMBER_WIDTH'(3);
	localparam logic [NUMBER_WIDTH-1:0] DIVISOR_STEP = NUMBER_WIDTH'(2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/trial_division_prime_test.sv -----
// Trial-division primality test. One number is taken per transaction on the
// in channel and one is_prime bit is returned on the out channel. Values
// below 4 and even values are settled at once, without the divider, and go
// straight to the finish state. An odd value of 5 or more is divided by 3, 5,
// 7 and so on until a divisor leaves no remainder or exceeds the quotient;
// each trial runs the bit-serial divider once. One number is in work at a
// time; a new one is taken while the previous result still waits in the
// output register.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [tdpt_pkg::NUMBER_WIDTH-1:0] number,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   is_prime
);
	import tdpt_pkg::*;

	state_t                  state_q, state_d;
	logic [NUMBER_WIDTH-1:0] n_q;
	logic [NUMBER_WIDTH-1:0] d_q;
	logic                    prime_q;
	logic                    out_valid_q;
	logic                    is_prime_q;

	logic                    start;
	logic                    d_load;
	logic                    d_step;
	logic                    prime_set;
	logic                    prime_val;
	logic                    out_load;
	logic [NUMBER_WIDTH-1:0] quotient;
	div_stat_t               stat;

	tdpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (n_q),
		.divisor  (d_q),
		.quotient (quotient),
		.stat     (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			n_q <= number;
		end
		if (d_load) begin
			d_q <= FIRST_DIVISOR;
		end else if (d_step) begin
			d_q <= d_q + DIVISOR_STEP;
		end
		if (prime_set) begin
			prime_q <= prime_val;
		end
		if (out_load) begin
			is_prime_q <= prime_q;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		start     = 1'b0;
		d_load    = 1'b0;
		d_step    = 1'b0;
		prime_set = 1'b0;
		prime_val = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if ({1'b0, number} < SMALL_LIMIT || !number[0]) begin
						// 2 and 3 are prime, 0, 1 and other evens are not
						prime_set = 1'b1;
						prime_val = ({1'b0, number} >= TWO_WIDE) &&
							({1'b0, number} < SMALL_LIMIT);
						state_d   = ST_FINISH;
					end else begin
						d_load  = 1'b1;
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				start   = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (stat.done) begin
					if (d_q > quotient) begin
						// divisor squared passed n with no factor found
						prime_set = 1'b1;
						prime_val = 1'b1;
						state_d   = ST_FINISH;
					end else if (stat.rem_zero) begin
						prime_set = 1'b1;
						prime_val = 1'b0;
						state_d   = ST_FINISH;
					end else begin
						d_step  = 1'b1;
						state_d = ST_START;
					end
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

endmodule

`default_nettype wire

// ----- rtl/core/tdpt_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. Dividend bits leave the top
// of the shift register while quotient bits enter at the bottom.
module tdpt_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [tdpt_pkg::NUMBER_WIDTH-1:0] dividend,
	input  wire logic [tdpt_pkg::NUMBER_WIDTH-1:0] divisor,
	output logic      [tdpt_pkg::NUMBER_WIDTH-1:0] quotient,
	output tdpt_pkg::div_stat_t                    stat
);
	import tdpt_pkg::*;

	logic [NUMBER_WIDTH-1:0] shift_q;
	logic [NUMBER_WIDTH-1:0] rem_q;
	logic [CNT_W-1:0]        count_q;
	logic                    busy_q;
	logic                    done_q;
	logic [NUMBER_WIDTH:0]   trial;
	logic [NUMBER_WIDTH:0]   diff;
	logic                    qbit;

	assign trial = {rem_q, shift_q[NUMBER_WIDTH-1]};
	assign diff  = trial - {1'b0, divisor};
	assign qbit  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= CNT_W'(NUMBER_WIDTH);
			end else if (busy_q) begin
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[NUMBER_WIDTH-2:0], qbit};
			// remainder stays below the divisor, so the top bit drops safely
			rem_q   <= qbit ? diff[NUMBER_WIDTH-1:0] : trial[NUMBER_WIDTH-1:0];
		end
	end

	assign quotient      = shift_q;
	assign stat.done     = done_q;
	assign stat.rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

// ----- rtl/core/tdpt_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "trial_division_prime_test_defines.svh"

module tdpt_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_stall,
	input wire logic [tdpt_pkg::NUMBER_WIDTH-1:0] number,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic                              is_prime
);
	import tdpt_pkg::*;

	logic in_acc;
	logic quick_zero;

	assign in_acc = in_valid && !in_stall;
	// values settled without division whose answer is zero: 0, 1, even >= 4
	assign quick_zero = ({1'b0, number} < TWO_WIDE) ||
		(!number[0] && {1'b0, number} >= SMALL_LIMIT);

	`TDPT_ASSERT_LOW_IN_RST(a_no_out_in_rst, clk, arst_n, out_valid, "out_valid in reset")
	`TDPT_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(is_prime), "stalled result dropped or changed")
	`TDPT_ASSERT(a_busy_after_acc, clk, arst_n, in_acc |=> in_stall, "second transaction taken while busy")
	`TDPT_ASSERT(a_quick_zero, clk, arst_n, in_acc && quick_zero && !out_valid |-> ##2 (out_valid && !is_prime), "trivial composite not reported in time")

endmodule

bind trial_division_prime_test tdpt_chk u_tdpt_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.number    (number),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.is_prime  (is_prime)
);

`default_nettype wire

// ----- verif/trial_division_prime_test_checker.sv -----
`timescale 1ns / 1ps

module trial_division_prime_test_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [tdpt_pkg::NUMBER_WIDTH-1:0] number,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              is_prime,
	output int                                errors,
	output int                                outstanding,
	output int                                checked,
	output int                                primes
);

	typedef logic [tdpt_pkg::NUMBER_WIDTH-1:0] number_t;

	typedef struct {
		number_t value;
		logic    prime;
	} verdict_t;

	verdict_t awaited_verdicts [$];

	// Odd trial divisors only; the bound d <= n / d avoids squaring d.
	function automatic logic prime_by_trial(input number_t n);
		number_t d;
		if (n < 2)
			return 1'b0;
		if (n < 4)
			return 1'b1;
		if (!n[0])
			return 1'b0;
		for (d = 3; d <= n / d; d += 2) begin
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t head;
		verdict_t fresh;
		if (!arst_n) begin
			awaited_verdicts.delete();
			errors <= 0;
			outstanding <= 0;
			checked <= 0;
			primes <= 0;
		end else begin
			// result side first: a result never belongs to the transaction taken at the same edge
			if (out_valid && !out_stall) begin
				if (awaited_verdicts.size() == 0) begin
					$display("%0t: unexpected result is_prime=%0b, expected nothing", $time,
						is_prime);
					errors <= errors + 1;
				end else begin
					head = awaited_verdicts.pop_front();
					checked <= checked + 1;
					if (head.prime)
						primes <= primes + 1;
					if (is_prime !== head.prime) begin
						$display("%0t: is_prime for %0d: expected %0b, actual %0b", $time,
							head.value, head.prime, is_prime);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				fresh.value = number;
				fresh.prime = prime_by_trial(number);
				awaited_verdicts.push_back(fresh);
			end
			outstanding <= awaited_verdicts.size();
		end
	end

endmodule

// ----- verif/trial_division_prime_test_test.sv -----
`timescale 1ns / 1ps

module trial_division_prime_test_test;

	localparam int W = tdpt_pkg::NUMBER_WIDTH;

	typedef logic [W-1:0] number_t;

	localparam number_t LARGEST = '1;
	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_NUMBERS = 78;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	number_t number = '0;
	logic    out_stall = 1'b0;
	logic    in_stall;
	logic    out_valid;
	logic    is_prime;

	int errors;
	int outstanding;
	int checked;
	int primes;

	// while set, neither side idles
	logic calm = 1'b0;
	int unsigned cycles = 0;

	// 2^31-1 is itself prime and is by far the slowest transaction
	number_t directed_numbers [$] = '{
		0, 1, 2, 3, 4, 5, 9, 15, 17, 25, 49, 97, 121, 63001, 65521, 65535,
		LARGEST, LARGEST - 1, LARGEST - 2, 31'h55555555, 31'h2AAAAAAA, 31'h40000000
	};

	trial_division_prime_test dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.number    (number),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_prime  (is_prime)
	);

	trial_division_prime_test_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.number      (number),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_prime    (is_prime),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.primes      (primes)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 37);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d results outstanding", cycles,
				outstanding);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_number(input number_t n);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		number <= n;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		number_t n;
		int unsigned f;
		int unsigned p;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_numbers[i])
			send_number(directed_numbers[i]);

		// most random values stay small or carry a small factor, so trials end early
		for (int i = 0; i < RANDOM_NUMBERS; i++) begin
			calm <= (i >= 40 && i < 70);
			case ($urandom_range(9))
				0, 1: n = number_t'($urandom) & ~number_t'(1);
				2, 3: n = number_t'($urandom_range(4095));
				4: n = number_t'($urandom_range(65535));
				5, 6, 7: begin
					f = 2 * $urandom_range(50, 1) + 1;
					n = number_t'(f * $urandom_range(LARGEST / f, 1));
				end
				8: begin
					p = 2 * $urandom_range(127, 1) + 1;
					n = number_t'(p * p);
				end
				default: n = number_t'($urandom_range(255));
			endcase
			send_number(n);
		end
		in_valid <= 1'b0;
		calm <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d numbers checked for primality, %0d of them prime, ranging 0 to %0d",
			checked, primes, LARGEST);
		$display("Covered squares of odd roots, small-factor composites and full-width evens");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
